// ===== rtl/core/dpb_pkg.sv =====
// Package for the depth pixel back-projection block.
// Holds widths, register and mode codes, configuration and job types.
// No dependencies; dpb_front, dpb_queue, dpb_back and the top module import it.
`default_nettype none

package dpb_pkg;

  localparam int FracBits    = 16;
  localparam int CntW        = 12;
  localparam int DepthW      = 10;
  localparam int ZW          = 26;
  localparam int XyW         = 41;
  localparam int DivW        = 42;
  localparam int DivCntW     = 6;
  localparam int MagW        = 17;
  localparam int WidthW      = 13;
  localparam int CfgAddrW    = 5;
  localparam int DefMaxWidth = 4096;

  // Register indexes.
  localparam logic [2:0] RegDepthMode  = 3'd0;
  localparam logic [2:0] RegColorSel   = 3'd1;
  localparam logic [2:0] RegDepthScale = 3'd2;
  localparam logic [2:0] RegCenterX    = 3'd3;
  localparam logic [2:0] RegCenterY    = 3'd4;
  localparam logic [2:0] RegFocalX     = 3'd5;
  localparam logic [2:0] RegFocalY     = 3'd6;
  localparam logic [2:0] RegImageWidth = 3'd7;

  // Depth modes.
  localparam logic [1:0] ModeSingle  = 2'd0;
  localparam logic [1:0] ModeSum     = 2'd1;
  localparam logic [1:0] ModeLayered = 2'd2;

  // Colour selections.
  localparam logic [1:0] ColBlue  = 2'd0;
  localparam logic [1:0] ColRed   = 2'd1;
  localparam logic [1:0] ColGreen = 2'd2;

  localparam logic [7:0]        ColourLevel = 8'd250;
  localparam logic [DepthW-1:0] LayerHigh   = 10'd511;
  localparam logic [DepthW-1:0] LayerMid    = 10'd255;

  typedef struct packed {
    logic [1:0]        depth_mode;
    logic [1:0]        color_select;
    logic [15:0]       depth_scale;
    logic [15:0]       center_x;
    logic [15:0]       center_y;
    logic [15:0]       focal_x;
    logic [15:0]       focal_y;
    logic [WidthW-1:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0]   col;
    logic [CntW-1:0]   row;
    logic [DepthW-1:0] depth;
  } job_t;

  // A job together with its valid flag, as it passes through the queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } qslot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVZ,
    S_MULX,
    S_DIVX,
    S_MULY,
    S_DIVY,
    S_FIN
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/dpb_if.sv =====
// Stream interfaces for depth pixels in and projected points out.
// Depends on nothing; valid and ready carry each transfer.
`default_nettype none

interface dpb_pix_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] chan_zero;
  logic [7:0] chan_one;
  logic [7:0] chan_two;

  modport source (output valid, frame_start, chan_zero, chan_one, chan_two, input ready);
  modport sink   (input valid, frame_start, chan_zero, chan_one, chan_two, output ready);
endinterface

interface dpb_pnt_if;
  logic               valid;
  logic               ready;
  logic signed [40:0] point_x;
  logic signed [40:0] point_y;
  logic        [25:0] point_z;
  logic        [7:0]  blue;
  logic        [7:0]  green;
  logic        [7:0]  red;

  modport source (output valid, point_x, point_y, point_z, blue, green, red, input ready);
  modport sink   (input valid, point_x, point_y, point_z, blue, green, red, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dpb_front.sv =====
// Front end: pixel position counters, depth code forming and dropping of empty pixels.
// Depends on dpb_pkg and dpb_pix_if.
`default_nettype none

module dpb_front import dpb_pkg::*; #(
  parameter int MaxWidth = DefMaxWidth
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  dpb_pix_if.sink    pix,
  input  cfg_t       cfg_i,
  input  wire        full_i,
  output qslot_t     push_o
);

  localparam logic [WidthW-1:0] MaxW = WidthW'(MaxWidth);

  logic [CntW-1:0]   col_q, col_d, row_q, row_d;
  logic [CntW-1:0]   col_cur, row_cur;
  logic [DepthW-1:0] depth;
  logic [WidthW-1:0] width_eff, col_inc;
  logic              accept;

  assign pix.ready = ~full_i;
  assign accept    = pix.valid & pix.ready;

  // Position of the current pixel; a frame start puts it at the origin.
  assign col_cur = pix.frame_start ? '0 : col_q;
  assign row_cur = pix.frame_start ? '0 : row_q;

  // Depth code according to the mode.
  always_comb begin
    case (cfg_i.depth_mode)
      ModeSum: begin
        depth = DepthW'(pix.chan_zero) + DepthW'(pix.chan_one) + DepthW'(pix.chan_two);
      end
      ModeLayered: begin
        if (pix.chan_two != 8'd0) begin
          depth = LayerHigh + DepthW'(pix.chan_two);
        end else if (pix.chan_one != 8'd0) begin
          depth = LayerMid + DepthW'(pix.chan_one);
        end else begin
          depth = DepthW'(pix.chan_zero);
        end
      end
      default: begin
        depth = DepthW'(pix.chan_zero);
      end
    endcase
  end

  // Counter advance with the row width held within its legal range.
  always_comb begin
    if (cfg_i.image_width == '0) begin
      width_eff = WidthW'(1);
    end else if (cfg_i.image_width > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = cfg_i.image_width;
    end
    col_inc = {1'b0, col_cur} + WidthW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= width_eff) begin
        col_d = '0;
        row_d = row_cur + CntW'(1);
      end else begin
        col_d = col_inc[CntW-1:0];
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Only pixels with a nonzero depth code become jobs.
  assign push_o.valid     = accept & (depth != '0);
  assign push_o.job.col   = col_cur;
  assign push_o.job.row   = row_cur;
  assign push_o.job.depth = depth;

endmodule

`default_nettype wire

// ===== rtl/core/dpb_queue.sv =====
// Two-entry job queue between the front end and the arithmetic back end.
// Depends on dpb_pkg.
`default_nettype none

module dpb_queue import dpb_pkg::*; (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  qslot_t push_i,
  input  wire    pop_i,
  output qslot_t head_o,
  output logic   full_o
);

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = slot_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i.valid) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_q] <= push_i.job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o && !pop_i)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid) else $error("job queue underflow");
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("job queue level out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dpb_back.sv =====
// Back end: depth division, projection products and divisions on one shared
// radix-2 divider, saturation and the output register. Depends on dpb_pkg, dpb_pnt_if.
`default_nettype none

module dpb_back import dpb_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  cfg_t      cfg_i,
  input  qslot_t    head_i,
  output logic      pop_o,
  dpb_pnt_if.source pnt
);

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivW - 1);

  back_state_e st_q, st_d;

  logic [DivCntW-1:0] cnt_q;
  logic [15:0]        rem_q;
  logic [DivW-1:0]    quo_q;
  logic [ZW-1:0]      z_q;
  logic [DivW-1:0]    qx_q;
  job_t               job_q;
  logic               ovld_q;
  logic [XyW-1:0]     ox_q, oy_q;
  logic [ZW-1:0]      oz_q;
  logic [7:0]         ob_q, og_q, or_q;

  logic [15:0]     divisor;
  logic [16:0]     shifted;
  logic [17:0]     trial;
  logic            digit;
  logic [15:0]     rem_n;
  logic            div_end;
  logic [MagW-1:0] dx, dy, mag_x, mag_y;
  logic [42:0]     prod;
  logic            out_free, out_load;

  function automatic logic [15:0] nz(input logic [15:0] v);
    nz = (v == 16'd0) ? 16'd1 : v;
  endfunction

  // Apply the sign to a quotient magnitude and clamp to the output range.
  function automatic logic [XyW-1:0] sat_xy(input logic neg, input logic [DivW-1:0] q);
    logic [DivW-1:0] lim;
    lim = DivW'(1) << (XyW - 1);
    if (neg) begin
      sat_xy = (q > lim) ? lim[XyW-1:0] : (~q[XyW-1:0] + XyW'(1));
    end else begin
      sat_xy = (q >= lim) ? (lim[XyW-1:0] - XyW'(1)) : q[XyW-1:0];
    end
  endfunction

  // Offsets from the principal point, in sixteenths of a pixel.
  assign dx    = {1'b0, job_q.col, 4'b0} - {1'b0, cfg_i.center_x};
  assign dy    = {1'b0, job_q.row, 4'b0} - {1'b0, cfg_i.center_y};
  assign mag_x = dx[MagW-1] ? (~dx + MagW'(1)) : dx;
  assign mag_y = dy[MagW-1] ? (~dy + MagW'(1)) : dy;

  // One multiplier, fed by the state.
  assign prod = (st_q == S_MULX) ? (mag_x * quo_q[ZW-1:0]) : (mag_y * z_q);

  // Divisor selected by the running division.
  always_comb begin
    case (st_q)
      S_DIVX:  divisor = nz(cfg_i.focal_x);
      S_DIVY:  divisor = nz(cfg_i.focal_y);
      default: divisor = nz(cfg_i.depth_scale);
    endcase
  end

  // One restoring division step.
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign trial   = {1'b0, shifted} - {2'b0, divisor};
  assign digit   = ~trial[17];
  assign rem_n   = digit ? trial[15:0] : shifted[15:0];
  assign div_end = (cnt_q == '0);

  assign out_free = ~ovld_q | pnt.ready;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (head_i.valid) st_d = S_DIVZ;
      S_DIVZ: if (div_end) st_d = S_MULX;
      S_MULX: st_d = S_DIVX;
      S_DIVX: if (div_end) st_d = S_MULY;
      S_MULY: st_d = S_DIVY;
      S_DIVY: if (div_end) st_d = S_FIN;
      S_FIN:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (st_q)
      S_IDLE:  pop_o    = head_i.valid;
      S_FIN:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (pnt.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        job_q <= head_i.job;
        rem_q <= '0;
        quo_q <= DivW'({head_i.job.depth, {FracBits{1'b0}}});
        cnt_q <= DivLast;
      end
      S_DIVZ, S_DIVX, S_DIVY: begin
        rem_q <= rem_n;
        quo_q <= {quo_q[DivW-2:0], digit};
        cnt_q <= cnt_q - DivCntW'(1);
      end
      S_MULX: begin
        z_q   <= quo_q[ZW-1:0];
        rem_q <= '0;
        quo_q <= prod[DivW-1:0];
        cnt_q <= DivLast;
      end
      S_MULY: begin
        qx_q  <= quo_q;
        rem_q <= '0;
        quo_q <= prod[DivW-1:0];
        cnt_q <= DivLast;
      end
      default: ;
    endcase
    if (out_load) begin
      ox_q <= sat_xy(dx[MagW-1], qx_q);
      oy_q <= sat_xy(dy[MagW-1], quo_q);
      oz_q <= z_q;
      ob_q <= (cfg_i.color_select == ColBlue)  ? ColourLevel : 8'd0;
      og_q <= (cfg_i.color_select == ColGreen) ? ColourLevel : 8'd0;
      or_q <= (cfg_i.color_select == ColRed)   ? ColourLevel : 8'd0;
    end
  end

  assign pnt.valid   = ovld_q;
  assign pnt.point_x = ox_q;
  assign pnt.point_y = oy_q;
  assign pnt.point_z = oz_q;
  assign pnt.blue    = ob_q;
  assign pnt.green   = og_q;
  assign pnt.red     = or_q;

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && head_i.valid) |=> (st_q == S_DIVZ && cnt_q == DivLast))
    else $error("job not started");
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_MULX || st_q == S_MULY) |=> cnt_q == DivLast)
    else $error("divider not reloaded");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN && !out_free) |=> st_q == S_FIN)
    else $error("result lost while output busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/depth_pixel_backprojection.sv =====
// Depth pixel back-projection: a front end forms depth codes and pixel positions and
// drops empty pixels, a two-entry queue decouples it from the back end, which finds
// z, x and y with one shared bit-serial divider and one multiplier. The front end
// takes a pixel whenever the queue is not full; the back end works on one job at a
// time (three 42-step divisions plus load, multiply and output steps) and takes the
// next job once the last point is loaded for output. Registers sit on an APB port.
// Depends on dpb_pkg, dpb_if, dpb_front, dpb_queue and dpb_back.
`default_nettype none

module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int MaxWidth = DefMaxWidth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [CfgAddrW-1:0] paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  dpb_pix_if.sink            pix_i,
  dpb_pnt_if.source          pnt_o
);

  cfg_t       cfg_q;
  qslot_t     push;
  qslot_t     head;
  logic       full;
  logic       pop;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[CfgAddrW-1:2];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_mode   <= ModeSingle;
      cfg_q.color_select <= ColBlue;
      cfg_q.depth_scale  <= 16'd1;
      cfg_q.center_x     <= 16'd5120;
      cfg_q.center_y     <= 16'd3200;
      cfg_q.focal_x      <= 16'd6400;
      cfg_q.focal_y      <= 16'd6400;
      cfg_q.image_width  <= 13'd640;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegDepthMode:  cfg_q.depth_mode   <= pwdata[1:0];
        RegColorSel:   cfg_q.color_select <= pwdata[1:0];
        RegDepthScale: cfg_q.depth_scale  <= pwdata[15:0];
        RegCenterX:    cfg_q.center_x     <= pwdata[15:0];
        RegCenterY:    cfg_q.center_y     <= pwdata[15:0];
        RegFocalX:     cfg_q.focal_x      <= pwdata[15:0];
        RegFocalY:     cfg_q.focal_y      <= pwdata[15:0];
        RegImageWidth: cfg_q.image_width  <= pwdata[WidthW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (idx)
      RegDepthMode:  prdata = 32'(cfg_q.depth_mode);
      RegColorSel:   prdata = 32'(cfg_q.color_select);
      RegDepthScale: prdata = 32'(cfg_q.depth_scale);
      RegCenterX:    prdata = 32'(cfg_q.center_x);
      RegCenterY:    prdata = 32'(cfg_q.center_y);
      RegFocalX:     prdata = 32'(cfg_q.focal_x);
      RegFocalY:     prdata = 32'(cfg_q.focal_y);
      RegImageWidth: prdata = 32'(cfg_q.image_width);
      default:       prdata = 32'd0;
    endcase
  end

  dpb_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix    (pix_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push)
  );

  dpb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  dpb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .pnt    (pnt_o)
  );

endmodule

`default_nettype wire
